// ----- rtl/array_list_insert_delete_assert.svh -----
// Assertion macros for the list insert/delete block.
`ifndef ARRAY_LIST_INSERT_DELETE_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_ASSERT_SVH
`ifndef SYNTHESIS
`define ALID_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("alid assertion failed");
`define ALID_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("alid forbidden condition");
`else
`define ALID_ASSERT(lbl, clk, rst_n, prop)
`define ALID_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/alid_pkg.sv -----
// Package: command codes, status codes, decoded op and state types.
`default_nettype none
package alid_pkg;
    localparam int DEPTH_DEFAULT = 16;
    localparam int CMD_W         = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 3;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADCMD = 3'd4;

    typedef enum logic [1:0] {K_INS, K_DEL, K_BAD} t_kind;
    typedef enum logic [1:0] {W_FRONT, W_BACK, W_POS} t_where;

    typedef struct packed {
        t_kind  kind;
        t_where where;
    } t_op;

    typedef enum logic {S_IDLE, S_EMIT} t_state;
endpackage
`default_nettype wire

// ----- rtl/alid_if.sv -----
// Command and result channel interfaces.
`default_nettype none
interface alid_cmd_if #(parameter int DEPTH = alid_pkg::DEPTH_DEFAULT) ();
    localparam int PW = $clog2(DEPTH + 2);
    logic                                valid;
    logic                                ready;
    logic [alid_pkg::CMD_W-1:0]          command;
    logic signed [alid_pkg::VALUE_W-1:0] value;
    logic [PW-1:0]                       position;
    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

interface alid_res_if #(parameter int DEPTH = alid_pkg::DEPTH_DEFAULT) ();
    localparam int IW = $clog2(DEPTH);
    logic                                valid;
    logic                                ready;
    logic signed [alid_pkg::VALUE_W-1:0] element;
    logic [IW-1:0]                       element_index;
    logic                                element_valid;
    logic [alid_pkg::STATUS_W-1:0]       status;
    logic                                last;
    modport source (output valid, element, element_index, element_valid, status, last,
                    input ready);
    modport sink   (input valid, element, element_index, element_valid, status, last,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/alid_front.sv -----
// Front end: accepts command words and decodes them into ops for the queue.
`default_nettype none
module alid_front #(
    parameter int DEPTH = alid_pkg::DEPTH_DEFAULT
) (
    alid_cmd_if.sink                              i_cmd,
    input  wire logic                             i_q_ready,
    output logic                                  o_q_valid,
    output alid_pkg::t_op                         o_q_op,
    output logic signed [alid_pkg::VALUE_W-1:0]   o_q_value,
    output logic [$clog2(DEPTH + 2)-1:0]          o_q_position
);
    import alid_pkg::*;

    assign i_cmd.ready  = i_q_ready;
    assign o_q_valid    = i_cmd.valid;
    assign o_q_value    = i_cmd.value;
    assign o_q_position = i_cmd.position;

    always_comb begin
        unique case (i_cmd.command)
            CMD_INS_FRONT: o_q_op = '{kind: K_INS, where: W_FRONT};
            CMD_INS_BACK:  o_q_op = '{kind: K_INS, where: W_BACK};
            CMD_INS_AT:    o_q_op = '{kind: K_INS, where: W_POS};
            CMD_DEL_FRONT: o_q_op = '{kind: K_DEL, where: W_FRONT};
            CMD_DEL_BACK:  o_q_op = '{kind: K_DEL, where: W_BACK};
            CMD_DEL_AT:    o_q_op = '{kind: K_DEL, where: W_POS};
            default:       o_q_op = '{kind: K_BAD, where: W_FRONT};
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/alid_fifo.sv -----
// Two-entry queue between the decoder and the list engine.
`default_nettype none
module alid_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_ready,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 2'd1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

// ----- rtl/alid_back.sv -----
// List engine: checks an op against the list, shifts the store in parallel, streams the list out.
`default_nettype none
`include "array_list_insert_delete_assert.svh"
module alid_back #(
    parameter int DEPTH = alid_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_q_valid,
    input  wire alid_pkg::t_op                         i_q_op,
    input  wire logic signed [alid_pkg::VALUE_W-1:0]   i_q_value,
    input  wire logic [$clog2(DEPTH + 2)-1:0]          i_q_position,
    output logic                                       o_q_pop,
    alid_res_if.source                                 o_res
);
    import alid_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH + 2);
    localparam int EW = PW + 1;

    logic signed [VALUE_W-1:0] r_store [DEPTH];
    logic signed [VALUE_W-1:0] n_store [DEPTH];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    t_state                    r_state;
    t_state                    n_state;
    logic [STATUS_W-1:0]       r_status;
    logic [STATUS_W-1:0]       w_exec_status;
    logic [IW-1:0]             r_idx;

    logic                      r_ov;
    logic signed [VALUE_W-1:0] r_oelem;
    logic [IW-1:0]             r_oidx;
    logic                      r_oev;
    logic [STATUS_W-1:0]       r_ost;
    logic                      r_olast;

    logic                      w_do_ins;
    logic                      w_do_del;
    logic [IW-1:0]             w_slot;
    logic [EW-1:0]             w_pos_x;
    logic [EW-1:0]             w_cnt_x;
    logic [EW-1:0]             w_slot_x;
    logic                      w_load;
    logic signed [VALUE_W-1:0] w_elem;
    logic                      w_ev;
    logic [STATUS_W-1:0]       w_st;
    logic                      w_last;

    assign w_pos_x  = EW'(i_q_position);
    assign w_cnt_x  = EW'(r_count);
    assign w_slot_x = EW'(w_slot);

    // Range checks: full/empty before position
    always_comb begin
        w_exec_status = ST_OK;
        w_slot        = '0;
        unique case (i_q_op.kind)
            K_INS: begin
                if (r_count == CW'(DEPTH)) begin
                    w_exec_status = ST_FULL;
                end else begin
                    unique case (i_q_op.where)
                        W_FRONT: w_slot = '0;
                        W_BACK:  w_slot = r_count[IW-1:0];
                        W_POS: begin
                            if (w_pos_x == '0 || w_pos_x > w_cnt_x + EW'(1))
                                w_exec_status = ST_BADPOS;
                            else
                                w_slot = IW'(w_pos_x - EW'(1));
                        end
                        default: w_exec_status = ST_BADCMD;
                    endcase
                end
            end
            K_DEL: begin
                if (r_count == '0) begin
                    w_exec_status = ST_EMPTY;
                end else begin
                    unique case (i_q_op.where)
                        W_FRONT: w_slot = '0;
                        W_BACK:  w_slot = IW'(w_cnt_x - EW'(1));
                        W_POS: begin
                            if (w_pos_x == '0 || w_pos_x > w_cnt_x)
                                w_exec_status = ST_BADPOS;
                            else
                                w_slot = IW'(w_pos_x - EW'(1));
                        end
                        default: w_exec_status = ST_BADCMD;
                    endcase
                end
            end
            default: w_exec_status = ST_BADCMD;
        endcase
    end

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign w_do_ins = o_q_pop && (w_exec_status == ST_OK) && (i_q_op.kind == K_INS);
    assign w_do_del = o_q_pop && (w_exec_status == ST_OK) && (i_q_op.kind == K_DEL);

    // Parallel shift: each slot picks itself, a neighbor or the new word
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_store[i] = r_store[i];
            if (w_do_ins) begin
                if (EW'(i) == w_slot_x)
                    n_store[i] = i_q_value;
                else if (EW'(i) > w_slot_x && EW'(i) <= w_cnt_x)
                    n_store[i] = r_store[(i > 0) ? i - 1 : 0];
            end else if (w_do_del) begin
                if (EW'(i) >= w_slot_x && EW'(i) + EW'(1) < w_cnt_x)
                    n_store[i] = r_store[(i + 1 < DEPTH) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins)      n_count = r_count + CW'(1);
        else if (w_do_del) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_do_ins || w_do_del) r_store <= n_store;
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_EMIT;
            S_EMIT: if (w_load && w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Result word for the current index
    always_comb begin
        w_load = (r_state == S_EMIT) && (!r_ov || o_res.ready);
        if (r_status != ST_OK || r_count == '0) begin
            w_elem = '0;
            w_ev   = 1'b0;
            w_st   = (r_status != ST_OK) ? r_status : ST_EMPTY;
            w_last = 1'b1;
        end else begin
            w_elem = r_store[r_idx];
            w_ev   = 1'b1;
            w_st   = ST_OK;
            w_last = (EW'(r_idx) + EW'(1) == w_cnt_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (o_q_pop)     r_idx <= '0;
            else if (w_load) r_idx <= r_idx + IW'(1);
            if (w_load)           r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_status <= w_exec_status;
        if (w_load) begin
            r_oelem <= w_elem;
            r_oidx  <= w_ev ? r_idx : '0;
            r_oev   <= w_ev;
            r_ost   <= w_st;
            r_olast <= w_last;
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.element       = r_oelem;
    assign o_res.element_index = r_oidx;
    assign o_res.element_valid = r_oev;
    assign o_res.status        = r_ost;
    assign o_res.last          = r_olast;

    `ALID_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(DEPTH))
    `ALID_ASSERT(a_count_step, i_clk, i_rst_n,
        r_count != $past(r_count) |->
            (r_count == $past(r_count) + CW'(1) || r_count + CW'(1) == $past(r_count)))
    // a held word may outlive the edit of the next command, so only its own fields are checked
    `ALID_ASSERT(a_entry_in_list, i_clk, i_rst_n, (r_ov && r_oev) |-> (r_ost == ST_OK))
endmodule
`default_nettype wire

// ----- rtl/array_list_insert_delete.sv -----
// Flow: a command is written into the queue when accepted; the engine pops it when
// idle, edits the list, and registers the first result word after the edit.
// A command returns n result words (1 to DEPTH), one per cycle while the result channel
// is ready; the queue holds two commands while the engine streams the previous one.
// Reset: synchronous active low; the list is empty and the queue drained after it.
`default_nettype none
module array_list_insert_delete #(
    parameter int DEPTH = alid_pkg::DEPTH_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    alid_cmd_if.sink   i_cmd,
    alid_res_if.source o_res
);
    import alid_pkg::*;

    localparam int PW = $clog2(DEPTH + 2);
    localparam int QW = $bits(t_op) + VALUE_W + PW;

    logic                      w_f_valid;
    t_op                       w_f_op;
    logic signed [VALUE_W-1:0] w_f_value;
    logic [PW-1:0]             w_f_pos;
    logic                      w_q_ready;
    logic                      w_q_valid;
    logic [QW-1:0]             w_q_data;
    logic                      w_q_pop;
    t_op                       w_b_op;
    logic signed [VALUE_W-1:0] w_b_value;
    logic [PW-1:0]             w_b_pos;

    alid_front #(.DEPTH(DEPTH)) u_front (
        .i_cmd        (i_cmd),
        .i_q_ready    (w_q_ready),
        .o_q_valid    (w_f_valid),
        .o_q_op       (w_f_op),
        .o_q_value    (w_f_value),
        .o_q_position (w_f_pos)
    );

    alid_fifo #(.W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  ({w_f_op, w_f_value, w_f_pos}),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign {w_b_op, w_b_value, w_b_pos} = w_q_data;

    alid_back #(.DEPTH(DEPTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_op       (w_b_op),
        .i_q_value    (w_b_value),
        .i_q_position (w_b_pos),
        .o_q_pop      (w_q_pop),
        .o_res        (o_res)
    );
endmodule
`default_nettype wire

// ----- tb/alid_checker.sv -----
// Result checker for the list insert/delete block: predicts result words per command.
`timescale 1ns / 100ps
module alid_checker #(
    parameter int DEPTH = alid_pkg::DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    alid_cmd_if  i_cmd,
    alid_res_if  i_res,
    output int   o_mismatches,
    output int   o_pending
);
    import alid_pkg::*;

    localparam int PW = $clog2(DEPTH + 2);
    localparam int IW = $clog2(DEPTH);

    typedef struct packed {
        logic signed [VALUE_W-1:0] element;
        logic [IW-1:0]             index;
        logic                      present;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } t_list_word;

    logic signed [VALUE_W-1:0] shadow_list [DEPTH];
    int                        shadow_count = 0;
    t_list_word                expected_words [$];

    function automatic t_list_word marker_word(input logic [STATUS_W-1:0] st);
        t_list_word w;
        w = '0;
        w.status = st;
        w.last   = 1'b1;
        return w;
    endfunction

    // Edit the shadow list and queue the words the block must return.
    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [VALUE_W-1:0] val,
                                 input logic [PW-1:0] pos);
        logic [STATUS_W-1:0] st;
        int                  slot;
        int                  i;
        t_list_word          w;
        st   = ST_OK;
        slot = 0;
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                if (shadow_count >= DEPTH) st = ST_FULL;
                else if (cmd == CMD_INS_FRONT) slot = 0;
                else if (cmd == CMD_INS_BACK) slot = shadow_count;
                else if (int'(pos) < 1 || int'(pos) > shadow_count + 1) st = ST_BADPOS;
                else slot = int'(pos) - 1;
                if (st == ST_OK) begin
                    for (i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[slot] = val;
                    shadow_count++;
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                if (shadow_count == 0) st = ST_EMPTY;
                else if (cmd == CMD_DEL_FRONT) slot = 0;
                else if (cmd == CMD_DEL_BACK) slot = shadow_count - 1;
                else if (int'(pos) < 1 || int'(pos) > shadow_count) st = ST_BADPOS;
                else slot = int'(pos) - 1;
                if (st == ST_OK) begin
                    for (i = slot; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            default: st = ST_BADCMD;
        endcase

        if (st != ST_OK) begin
            expected_words.push_back(marker_word(st));
        end else if (shadow_count == 0) begin
            expected_words.push_back(marker_word(ST_EMPTY));
        end else begin
            for (i = 0; i < shadow_count; i++) begin
                w.element = shadow_list[i];
                w.index   = IW'(i);
                w.present = 1'b1;
                w.status  = ST_OK;
                w.last    = (i + 1 == shadow_count);
                expected_words.push_back(w);
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_list_word seen;
        t_list_word want;
        if (!i_rst_n) begin
            o_mismatches = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                seen.element = i_res.element;
                seen.index   = i_res.element_index;
                seen.present = i_res.element_valid;
                seen.status  = i_res.status;
                seen.last    = i_res.last;
                if (expected_words.size() == 0) begin
                    $display({"%0t: unexpected word: expected none, got elem=%0d idx=%0d ",
                              "vld=%0b st=%0d last=%0b"},
                             $time, seen.element, seen.index, seen.present, seen.status,
                             seen.last);
                    o_mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (seen.element !== want.element || seen.index !== want.index ||
                        seen.present !== want.present || seen.status !== want.status ||
                        seen.last !== want.last) begin
                        $display({"%0t: word mismatch: expected elem=%0d idx=%0d vld=%0b ",
                                  "st=%0d last=%0b, got elem=%0d idx=%0d vld=%0b st=%0d ",
                                  "last=%0b"},
                                 $time, want.element, want.index, want.present,
                                 want.status, want.last, seen.element, seen.index,
                                 seen.present, seen.status, seen.last);
                        o_mismatches++;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                apply_command(i_cmd.command, i_cmd.value, i_cmd.position);
        end
        o_pending = expected_words.size();
    end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the list insert/delete block: command stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_top;
    import alid_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int PW           = $clog2(DEPTH + 2);
    localparam int RANDOM_CMDS  = 160;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    // command codes the block must reject
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    bit   steady = 1'b0;
    int   ready_hold = 0;
    int   quiet_cycles = 0;
    int   fill = 0;
    int   mismatches;
    int   pending_words;

    alid_cmd_if #(.DEPTH(DEPTH)) cmd_if ();
    alid_res_if #(.DEPTH(DEPTH)) res_if ();

    array_list_insert_delete #(.DEPTH(DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    alid_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_mismatches (mismatches),
        .o_pending    (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            ready_hold   <= 0;
        end else if (steady) begin
            res_if.ready <= 1'b1;
            ready_hold   <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (res_if.ready) begin
            res_if.ready <= 1'b0;
            ready_hold   <= idle_len();
        end else begin
            res_if.ready <= 1'b1;
            ready_hold   <= $urandom_range(0, 12);
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd,
                            input logic signed [VALUE_W-1:0] val,
                            input logic [PW-1:0] pos);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.command  <= cmd;
        cmd_if.value    <= val;
        cmd_if.position <= pos;
        do @(posedge i_clk); while (!cmd_if.ready);
        // fill level only steers the random mix toward full and empty
        if (cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK || cmd == CMD_INS_AT) begin
            if (fill < DEPTH && (cmd != CMD_INS_AT || (pos >= 1 && int'(pos) <= fill + 1)))
                fill++;
        end else if (cmd == CMD_DEL_FRONT || cmd == CMD_DEL_BACK || cmd == CMD_DEL_AT) begin
            if (fill > 0 && (cmd != CMD_DEL_AT || (pos >= 1 && int'(pos) <= fill)))
                fill--;
        end
    endtask

    task automatic run_random();
        int   k;
        int   r;
        int   top_pos;
        bit   filling;
        logic [CMD_W-1:0] cmd;
        logic [PW-1:0]    pos;
        filling = 1'b1;
        for (k = 0; k < RANDOM_CMDS; k++) begin
            if (k % 50 == 0) steady = ((k / 50) % 2 == 1);
            if (fill == DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
            if (fill == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                cmd = (r < 2) ? CMD_RSVD_6 : CMD_RSVD_7;
            end else if ((r < 80) == filling) begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_INS_FRONT;
                    1: cmd = CMD_INS_BACK;
                    default: cmd = CMD_INS_AT;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_DEL_FRONT;
                    1: cmd = CMD_DEL_BACK;
                    default: cmd = CMD_DEL_AT;
                endcase
            end
            top_pos = (cmd == CMD_INS_AT) ? fill + 1 : ((fill == 0) ? 1 : fill);
            if ($urandom_range(0, 4) == 0)
                pos = PW'($urandom_range(0, (1 << PW) - 1));
            else
                pos = PW'($urandom_range(1, top_pos));
            send_cmd(cmd, $urandom(), pos);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.command  <= CMD_INS_FRONT;
        cmd_if.value    <= '0;
        cmd_if.position <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, rejected codes, out-of-range positions, valid inserts and deletes
        send_cmd(CMD_DEL_FRONT, 32'sd5, 5'd1);
        send_cmd(CMD_DEL_BACK, 32'sd5, 5'd1);
        send_cmd(CMD_DEL_AT, 32'sd5, 5'd1);
        send_cmd(CMD_RSVD_6, WORD_MAX, 5'd31);
        send_cmd(CMD_RSVD_7, WORD_MIN, 5'd0);
        send_cmd(CMD_INS_AT, 32'sd1, 5'd0);
        send_cmd(CMD_INS_AT, 32'sd1, 5'd2);
        send_cmd(CMD_INS_AT, WORD_MIN, 5'd1);
        send_cmd(CMD_INS_FRONT, WORD_MAX, 5'd0);
        send_cmd(CMD_INS_BACK, -32'sd1, 5'd31);
        send_cmd(CMD_INS_BACK, 32'sd0, 5'd0);
        send_cmd(CMD_INS_AT, 32'sh5555_5555, 5'd3);
        send_cmd(CMD_INS_AT, 32'shAAAA_AAAA, 5'd6);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd0);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd7);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd31);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd3);
        send_cmd(CMD_DEL_FRONT, 32'sd0, 5'd0);
        send_cmd(CMD_DEL_BACK, 32'sd0, 5'd0);
        // fill up, then hit the full list
        while (fill < DEPTH)
            send_cmd(fill[0] ? CMD_INS_FRONT : CMD_INS_BACK, $urandom(), 5'd0);
        send_cmd(CMD_INS_FRONT, 32'sd7, 5'd0);
        send_cmd(CMD_INS_AT, 32'sd7, 5'd31);
        send_cmd(CMD_INS_BACK, 32'sd7, 5'd1);
        send_cmd(CMD_DEL_AT, 32'sd0, 5'd16);

        run_random();

        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_words == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
